// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SQA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define SQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SQA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SQA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/sqa_pkg.sv =====
package sqa_pkg;

    localparam int BANK_COUNT_DEF = 8;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] ANCHOR_NW = 2'b00;
    localparam logic [1:0] ANCHOR_NE = 2'b01;
    localparam logic [1:0] ANCHOR_SW = 2'b10;
    localparam logic [1:0] ANCHOR_SE = 2'b11;

    localparam logic [7:0] HEAD_NW = 8'd16;
    localparam logic [7:0] HEAD_NE = 8'd32;
    localparam logic [7:0] HEAD_SW = 8'd64;
    localparam logic [7:0] HEAD_SE = 8'd128;

    localparam logic [3:0] SHAPE_FULL = 4'd15;
    localparam logic [3:0] SHAPE_WIDE = 4'd3;
    localparam logic [3:0] SHAPE_TALL = 4'd5;
    localparam logic [3:0] SHAPE_ONE  = 4'd1;

    localparam logic [7:0] EAST_COLUMN  = 8'b0000_1010;
    localparam logic [7:0] SOUTH_ROW    = 8'b0000_1100;
    localparam logic [7:0] SE_QUAD      = 8'b0000_1000;
    localparam logic [3:0] EAST_BITS    = 4'b1010;
    localparam logic [3:0] SOUTH_BITS   = 4'b1100;
    localparam logic [7:0] NO_SLOT      = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic       hit;
        logic [1:0] anchor;
        logic [7:0] rec;
    } t_alloc_res;

    // Tries the four anchors of one bank in order; the shifted mask is tested
    // against the whole record, head bits included.
    function automatic t_alloc_res alloc_eval(input logic [7:0] r, input logic [3:0] m);
        t_alloc_res res;
        logic [7:0] m0;
        logic [7:0] s1;
        logic [7:0] s2;
        m0  = {4'b0000, m};
        s1  = m0 << 1;
        s2  = m0 << 2;
        res.hit    = 1'b0;
        res.anchor = ANCHOR_NW;
        res.rec    = r;
        if ((r & m0) == 8'd0) begin
            res.hit = 1'b1;
            res.rec = r | m0 | HEAD_NW;
        end else if (m == SHAPE_FULL) begin
            res.hit = 1'b0;
        end else if ((m != SHAPE_WIDE) && ((r & s1) == 8'd0)) begin
            res.hit    = 1'b1;
            res.anchor = ANCHOR_NE;
            res.rec    = r | (s1 & EAST_COLUMN) | HEAD_NE;
        end else if ((m != SHAPE_TALL) && ((r & s2) == 8'd0)) begin
            res.hit    = 1'b1;
            res.anchor = ANCHOR_SW;
            res.rec    = r | (s2 & SOUTH_ROW) | HEAD_SW;
        end else if ((m == SHAPE_ONE) && !r[3]) begin
            res.hit    = 1'b1;
            res.anchor = ANCHOR_SE;
            res.rec    = r | SE_QUAD | HEAD_SE;
        end
        return res;
    endfunction

    // Clears the quadrants owned by one anchor, sparing quadrants of other heads.
    function automatic logic [7:0] free_rec(input logic [7:0] r, input logic [1:0] anchor);
        logic [3:0] nh;
        logic [3:0] c;
        nh = ~r[7:4];
        case (anchor)
            ANCHOR_NW: begin
                c = nh | 4'b0001;
                if (c[2:1] != 2'b11) begin
                    c = c & 4'b0111;
                end
            end
            ANCHOR_NE: c = (nh & EAST_BITS) | 4'b0010;
            ANCHOR_SW: c = (nh & SOUTH_BITS) | 4'b0100;
            default:   c = 4'b1000;
        endcase
        return r & ~{c, c};
    endfunction

endpackage

// ===== design/sqa_ctrl.sv =====
module sqa_ctrl import sqa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_func,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.last) begin
                    if (i_sts.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FREE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sqa_dp.sv =====
module sqa_dp import sqa_pkg::*; #(
    parameter int BANK_COUNT = BANK_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_func,
    input  logic [3:0] i_page_mask,
    input  logic [7:0] i_slot,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_slot_out,
    output logic       o_granted
);

    localparam int IDX_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    logic [7:0]       r_rec [BANK_COUNT];
    logic [7:0]       n_rec [BANK_COUNT];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_func;
    logic [3:0]       r_mask;
    logic [7:0]       r_slot;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_slot_out;
    logic             r_granted;

    logic [IDX_W-1:0] w_sel;
    logic [7:0]       w_rd;
    t_alloc_res       w_alloc;
    logic [7:0]       w_freed;
    logic             w_bank_ok;
    logic             w_we;
    logic [7:0]       w_wdata;
    logic [7:0]       w_res_slot;
    logic             w_res_grant;

    assign w_sel     = (r_func == FUNC_FREE) ? r_slot[IDX_W-1:0] : r_idx;
    assign w_rd      = r_rec[w_sel];
    assign w_alloc   = alloc_eval(w_rd, r_mask);
    assign w_freed   = free_rec(w_rd, r_slot[7:6]);
    assign w_bank_ok = ({1'b0, r_slot[2:0]} < 4'(BANK_COUNT));

    assign w_we    = i_cmd.commit && ((r_func == FUNC_FREE) ? w_bank_ok : w_alloc.hit);
    assign w_wdata = (r_func == FUNC_FREE) ? w_freed : w_alloc.rec;

    always_comb begin
        if (r_func == FUNC_FREE) begin
            w_res_slot  = r_slot;
            w_res_grant = w_bank_ok;
        end else if (w_alloc.hit) begin
            w_res_slot  = {w_alloc.anchor, 3'b000, 3'(r_idx)};
            w_res_grant = 1'b1;
        end else begin
            w_res_slot  = NO_SLOT;
            w_res_grant = 1'b0;
        end
    end

    always_comb begin
        for (int b = 0; b < BANK_COUNT; b++) begin
            n_rec[b] = r_rec[b];
            if (w_we && (w_sel == IDX_W'(b))) begin
                n_rec[b] = w_wdata;
            end
        end
        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.step) begin
            n_idx = r_idx + 1'b1;
        end
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANK_COUNT; b++) begin
                r_rec[b] <= '0;
            end
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rec       <= n_rec;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_mask <= i_page_mask;
            r_slot <= i_slot;
        end
        if (i_cmd.commit) begin
            r_slot_out <= w_res_slot;
            r_granted  <= w_res_grant;
        end
    end

    assign o_sts.hit      = w_alloc.hit;
    assign o_sts.last     = (r_idx == IDX_W'(BANK_COUNT - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_slot_out  = r_slot_out;
    assign o_granted   = r_granted;

endmodule

// ===== design/sprite_quadrant_allocator.sv =====
// Channel   Direction  Handshake               Payload
// request   in         i_in_valid / o_in_stall i_func, i_page_mask, i_slot
// result    out        o_out_valid / i_out_stall o_slot_out, o_granted
//
// An allocation captures the beat, then examines the bank records one at a
// time through the single record read port; a free captures the beat, then
// commits. Reset is synchronous and active low and clears every bank record at
// once. The result sits in an output register, so a new request is taken while
// a finished result still waits; a request only pauses at its commit when that
// register is still occupied and stalled.

`include "assert_macros.svh"

module sprite_quadrant_allocator import sqa_pkg::*; #(
    parameter int BANK_COUNT = BANK_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [3:0] i_page_mask,
    input  logic [7:0] i_slot,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_slot_out,
    output logic       o_granted
);

    // The controller sequences capture, bank-by-bank scan and commit; the
    // datapath owns the bank records and the result register.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sqa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    sqa_dp #(
        .BANK_COUNT (BANK_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (i_func),
        .i_page_mask (i_page_mask),
        .i_slot      (i_slot),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_slot_out  (o_slot_out),
        .o_granted   (o_granted)
    );

    // Once a beat is taken, no second beat may enter before its result commits.
    `SQA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A result is only written when the output register can take it.
    `SQA_ASSERT_IMPLY(a_commit_has_room, i_clk, i_rst_n, w_cmd.commit, w_sts.out_free)
    // A commit always presents a result beat on the next cycle.
    `SQA_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit, o_out_valid)
    // The scan never advances past the last bank.
    `SQA_ASSERT_IMPLY(a_no_step_past_end, i_clk, i_rst_n, w_cmd.step, !w_sts.last)

endmodule
